@@ design/mtdm_pkg.sv @@
`default_nettype none

package mtdm_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int GAIN_W    = 16;
   localparam int WORD_W    = 32;
   localparam int FRAC_BITS = 14;
   localparam int PROD_W    = SAMPLE_W + GAIN_W;
   // dry term plus at most six tap terms
   localparam int ACC_W     = PROD_W + 3;
   localparam int CNT_W     = 3;
   localparam int CSR_IDX_W = 8;
   localparam int POS_W     = 18;

   localparam logic [CSR_IDX_W-1:0] CSR_TAP_COUNT = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DRY_GAIN  = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TAP0      = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TAP5      = 8'd7;

   localparam logic [CNT_W-1:0]  TAP_COUNT_RST = 3'd1;
   localparam logic [WORD_W-1:0] TAP0_WORD_RST = 32'h4000_1000;
   localparam logic [WORD_W-1:0] TAPN_WORD_RST = 32'h0000_0001;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_RUN   = 3'b100
   } state_type;

endpackage

`default_nettype wire

@@ design/mtdm_ram.sv @@
`default_nettype none

module mtdm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/multitap_delay_mix_unit.sv @@
`default_nettype none

// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  req_sample_in   (16 b signed Q1.15)
// rsp_      out        rsp_valid/rsp_stall  rsp_sample_out  (16 b signed Q1.15)
// csr_      in         csr_valid/csr_ready  csr_index (8 b), csr_wdata (32 b)
//
// items are taken one at a time: the dry term, then n tap reads (n the active
// tap count), one read a cycle on the memory's single read port
// after reset the delay memory is zeroed, one entry a cycle, with req_stall
// high until it is done; csr writes are taken at all times
// a result waits in the output register while rsp_stall is high; the next item
// is still taken and runs until it needs that register

module multitap_delay_mix_unit #(
   parameter int DEPTH = 4096,
   parameter int TAPS  = 6
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [mtdm_pkg::SAMPLE_W-1:0] req_sample_in,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [mtdm_pkg::SAMPLE_W-1:0]     rsp_sample_out,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [mtdm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [mtdm_pkg::WORD_W-1:0]         csr_wdata
);

   localparam int AW = $clog2(DEPTH);
   localparam int TW = (TAPS > 1) ? $clog2(TAPS) : 1;

   // configuration registers
   logic [mtdm_pkg::CNT_W-1:0]         tap_count_ff;
   logic signed [mtdm_pkg::GAIN_W-1:0] dry_gain_ff;
   logic [mtdm_pkg::WORD_W-1:0]        tap_word_ff [TAPS];

   // control
   mtdm_pkg::state_type state_ff, state_in;
   logic [AW-1:0]                 clr_addr_ff, clr_addr_in;
   logic [AW-1:0]                 wp_ff, wp_in;
   logic [mtdm_pkg::CNT_W-1:0]    rd_cnt_ff, rd_cnt_in;
   logic [mtdm_pkg::CNT_W-1:0]    n_taps_ff, n_taps_in;
   logic                          rdv_ff, rdv_in;
   logic                          prodv_ff, prodv_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // datapath
   logic signed [mtdm_pkg::SAMPLE_W-1:0] x_ff, x_in;
   logic signed [mtdm_pkg::GAIN_W-1:0]   g_ff, g_in;
   logic signed [mtdm_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic signed [mtdm_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic signed [mtdm_pkg::SAMPLE_W-1:0] out_ff, out_in;

   logic accept, issue, done, finish;
   logic [mtdm_pkg::CNT_W-1:0] n_eff;
   logic [mtdm_pkg::WORD_W-1:0] cur_word;
   logic [16:0] dly;
   logic [mtdm_pkg::POS_W-1:0] pos;
   logic signed [mtdm_pkg::SAMPLE_W-1:0] mul_a;
   logic signed [mtdm_pkg::GAIN_W-1:0]   mul_b;
   logic signed [mtdm_pkg::ACC_W-mtdm_pkg::FRAC_BITS-1:0] y_sh;

   // memory ports
   logic                              mem_we, mem_re;
   logic [AW-1:0]                     mem_waddr, mem_raddr;
   logic [mtdm_pkg::SAMPLE_W-1:0]     mem_wdata, mem_rdata;

   mtdm_ram #(
      .WIDTH(mtdm_pkg::SAMPLE_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_en  (mem_re),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   // csr port never pushes back
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= mtdm_pkg::TAP_COUNT_RST;
         dry_gain_ff  <= '0;
         for (int t = 0; t < TAPS; t++) begin
            tap_word_ff[t] <= (t == 0) ? mtdm_pkg::TAP0_WORD_RST : mtdm_pkg::TAPN_WORD_RST;
         end
      end else if (csr_valid) begin
         case (csr_index) inside
            mtdm_pkg::CSR_TAP_COUNT: begin
               tap_count_ff <= csr_wdata[mtdm_pkg::CNT_W-1:0];
            end
            mtdm_pkg::CSR_DRY_GAIN: begin
               dry_gain_ff <= csr_wdata[mtdm_pkg::GAIN_W-1:0];
            end
            [mtdm_pkg::CSR_TAP0:mtdm_pkg::CSR_TAP5]: begin
               for (int t = 0; t < TAPS; t++) begin
                  if (csr_index == mtdm_pkg::CSR_IDX_W'(int'(mtdm_pkg::CSR_TAP0) + t)) begin
                     tap_word_ff[t] <= csr_wdata;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // tap count saturates at the number of built taps
   assign n_eff = (tap_count_ff > mtdm_pkg::CNT_W'(TAPS)) ?
                  mtdm_pkg::CNT_W'(TAPS) : tap_count_ff;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != mtdm_pkg::ST_IDLE);

   assign issue  = (state_ff == mtdm_pkg::ST_RUN) && (rd_cnt_ff < n_taps_ff);
   // all reads issued and the multiply/accumulate pipe drained
   assign done   = (state_ff == mtdm_pkg::ST_RUN) && !issue && !rdv_ff && !prodv_ff;
   assign finish = done && !(rsp_valid_ff && rsp_stall);

   // tap address: clamp delay into 1..DEPTH, then step back from the write pointer
   always_comb begin
      cur_word = tap_word_ff[rd_cnt_ff[TW-1:0]];
      dly = {1'b0, cur_word[15:0]};
      if (dly == 17'd0) begin
         dly = 17'd1;
      end
      if (dly > 17'(DEPTH)) begin
         dly = 17'(DEPTH);
      end
      pos = mtdm_pkg::POS_W'(wp_ff) - mtdm_pkg::POS_W'(dly);
      if (pos[mtdm_pkg::POS_W-1]) begin
         pos = pos + mtdm_pkg::POS_W'(DEPTH);
      end
   end

   assign mem_re    = issue;
   assign mem_raddr = pos[AW-1:0];

   // write port: zeroing sweep, or the new sample once its reads are done and the result is stored
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = wp_ff;
      mem_wdata = x_ff;
      if (state_ff == mtdm_pkg::ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else if (finish) begin
         mem_we = 1'b1;
      end
   end

   // one shared multiplier: dry term on accept, tap terms as reads return
   assign mul_a   = accept ? req_sample_in : $signed(mem_rdata);
   assign mul_b   = accept ? dry_gain_ff : g_ff;
   assign prod_in = mul_a * mul_b;

   // floor shift then saturate
   assign y_sh = acc_ff[mtdm_pkg::ACC_W-1:mtdm_pkg::FRAC_BITS];

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      wp_in        = wp_ff;
      rd_cnt_in    = rd_cnt_ff;
      n_taps_in    = n_taps_ff;
      rdv_in       = issue;
      prodv_in     = accept || rdv_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      x_in         = x_ff;
      g_in         = g_ff;
      acc_in       = acc_ff;
      out_in       = out_ff;

      if (issue) begin
         g_in      = cur_word[31:16];
         rd_cnt_in = rd_cnt_ff + 1'b1;
      end
      if (prodv_ff) begin
         acc_in = acc_ff + mtdm_pkg::ACC_W'(prod_ff);
      end

      case (state_ff)
         mtdm_pkg::ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in = mtdm_pkg::ST_IDLE;
            end
         end
         mtdm_pkg::ST_IDLE: begin
            if (accept) begin
               x_in      = req_sample_in;
               acc_in    = '0;
               rd_cnt_in = '0;
               n_taps_in = n_eff;
               state_in  = mtdm_pkg::ST_RUN;
            end
         end
         mtdm_pkg::ST_RUN: begin
            if (finish) begin
               if (y_sh > 21'sd32767) begin
                  out_in = 16'sh7fff;
               end else if (y_sh < -21'sd32768) begin
                  out_in = -16'sh8000;
               end else begin
                  out_in = y_sh[mtdm_pkg::SAMPLE_W-1:0];
               end
               rsp_valid_in = 1'b1;
               wp_in = (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
               state_in = mtdm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mtdm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mtdm_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         wp_ff        <= '0;
         rd_cnt_ff    <= '0;
         n_taps_ff    <= '0;
         rdv_ff       <= 1'b0;
         prodv_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         wp_ff        <= wp_in;
         rd_cnt_ff    <= rd_cnt_in;
         n_taps_ff    <= n_taps_in;
         rdv_ff       <= rdv_in;
         prodv_ff     <= prodv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      g_ff    <= g_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      out_ff  <= out_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = out_ff;

endmodule

`default_nettype wire
